// ===== hw/rtl/ffa_pkg.sv =====
// Shared constants, result codes and cell control types of the first-fit allocator.
package ffa_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int HEAP_BYTES_DEF = 65536;
    localparam int HEADER_BYTES   = 16;
    localparam int ALIGN_BYTES    = 8;   // power of two

    localparam int SIZE_W   = 16;
    localparam int NEED_W   = SIZE_W + 1;
    localparam int ADDR_W   = 16;
    localparam int STATUS_W = 3;
    localparam int LIMIT_W  = 17;
    localparam int LIMIT_RST = 65536;
    localparam int ADDR_MAX = 65535;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_TAKE_RIGHT,
        CELL_TAKE_LEFT
    } cell_sel_t;

    typedef struct packed {
        cell_sel_t sel;
        logic      kill;
    } cell_ctl_t;

endpackage

// ===== hw/rtl/ffa_cell.sv =====
// One block-table entry of the allocator's cell row.
module ffa_cell #(
    parameter int AW = $clog2(ffa_pkg::HEAP_BYTES_DEF + 1)
) (
    input  logic              clk,
    input  ffa_pkg::cell_ctl_t ctl,
    input  logic [AW-1:0]     right_start,
    input  logic [AW-1:0]     right_bytes,
    input  logic              right_free,
    input  logic              right_keep,
    input  logic [AW-1:0]     left_start,
    input  logic [AW-1:0]     left_bytes,
    input  logic              left_free,
    input  logic              left_keep,
    output logic [AW-1:0]     start,
    output logic [AW-1:0]     bytes,
    output logic              free,
    output logic              keep
);

    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] bytes_reg, bytes_next;
    logic          free_reg, free_next;
    logic          keep_reg, keep_next;

    always_comb
    begin
        unique case (ctl.sel)
            ffa_pkg::CELL_TAKE_RIGHT:
            begin
                start_next = right_start;
                bytes_next = right_bytes;
                free_next  = right_free;
                keep_next  = right_keep;
            end
            ffa_pkg::CELL_TAKE_LEFT:
            begin
                start_next = left_start;
                bytes_next = left_bytes;
                free_next  = left_free;
                keep_next  = left_keep;
            end
            default:
            begin
                start_next = start_reg;
                bytes_next = bytes_reg;
                free_next  = free_reg;
                keep_next  = keep_reg;
            end
        endcase
        // drop the entry that was just absorbed by its successor
        if (ctl.kill)
        begin
            keep_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        bytes_reg <= bytes_next;
        free_reg  <= free_next;
        keep_reg  <= keep_next;
    end

    assign start = start_reg;
    assign bytes = bytes_reg;
    assign free  = free_reg;
    assign keep  = keep_reg;

endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit allocator: sequencer and the rotating row of table cells.
//
//  channel   dir  handshake        payload
//  s_*       in   tvalid/tready    tuser[0] opcode; tdata[15:0] alloc_size, [31:16] free_address
//  m_*       out  tvalid/tready    tdata[15:0] address, [18:16] status, [23:19] zero
//  cfg_*     in   cfg_wr_en        cfg_wr_data: heap_limit
//
// Allocate: one rotation of the row, then the result is posted.
// Free: three row passes (search, coalesce, compaction), then the result is posted.
// Null free: no row pass, the result is posted directly. The row rotation takes one entry at the head per cycle.
// Reset empties the table (count and heap top to zero); the cells hold no reset.
// A result waits in the output register; the next beat is taken while it waits,
// and the sequencer only stalls when a second result is ready before the first leaves.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF,
    parameter int HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // alloc_size [15:0], free_address [31:16]
    input  logic [0:0]  s_tuser,    // opcode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // address [15:0], status [18:16], zero [23:19]
    input  logic        cfg_wr_en,
    input  logic [ffa_pkg::LIMIT_W-1:0] cfg_wr_data
);

    localparam int AW   = $clog2(HEAP_BYTES + 1);
    localparam int CNTW = $clog2(MAX_BLOCKS + 1);
    localparam int CW   = ((AW > ffa_pkg::LIMIT_W) ? AW : ffa_pkg::LIMIT_W) + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_MERGE = 3'd3;
    localparam logic [2:0] S_PACK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [CNTW-1:0] step_reg, step_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] merges_reg, merges_next;
    logic            found_reg, found_next;
    logic            prev_ok_reg, prev_ok_next;
    logic [AW-1:0]   heap_top_reg, heap_top_next;
    logic [ffa_pkg::LIMIT_W-1:0] limit_reg;
    logic [ffa_pkg::NEED_W-1:0]  need_reg, need_next;
    logic [ffa_pkg::ADDR_W-1:0]  faddr_reg, faddr_next;
    logic [ffa_pkg::ADDR_W-1:0]  res_reg, res_next;
    logic [ffa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic            out_valid_reg, out_valid_next;
    logic [ffa_pkg::ADDR_W-1:0]  out_addr_reg, out_addr_next;
    logic [ffa_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    // cell row, index 0 is the head
    logic [AW-1:0] c_start [MAX_BLOCKS];
    logic [AW-1:0] c_bytes [MAX_BLOCKS];
    logic          c_free  [MAX_BLOCKS];
    logic          c_keep  [MAX_BLOCKS];
    logic [AW-1:0] tail_start, tail_bytes;
    logic          tail_free, tail_keep;
    logic          merge_kill;
    logic [MAX_BLOCKS-2:0] swap;

    logic            step_last, in_range, fit, append_now, match, merge_now;
    logic            found_any, room, load;
    logic [CW-1:0]   lim, end_addr, top_hdr, head_addr;
    logic [ffa_pkg::NEED_W-1:0] need_in;

    assign s_tready  = (state_reg == S_IDLE);
    assign step_last = (step_reg == CNTW'(MAX_BLOCKS - 1));
    assign in_range  = (step_reg < count_reg);

    // round the request up to the alignment
    assign need_in = ffa_pkg::NEED_W'(((ffa_pkg::NEED_W'(s_tdata[15:0])
                     + ffa_pkg::NEED_W'(ffa_pkg::ALIGN_BYTES - 1)) / ffa_pkg::ALIGN_BYTES)
                     * ffa_pkg::ALIGN_BYTES);

    assign lim = (CW'(limit_reg) < CW'(HEAP_BYTES)) ? CW'(limit_reg) : CW'(HEAP_BYTES);
    assign top_hdr  = CW'(heap_top_reg) + CW'(ffa_pkg::HEADER_BYTES);
    assign end_addr = top_hdr + CW'(need_reg);
    assign room     = (end_addr <= lim) && (top_hdr <= CW'(ffa_pkg::ADDR_MAX));
    assign head_addr = CW'(c_start[0]) + CW'(ffa_pkg::HEADER_BYTES);

    assign fit        = (state_reg == S_ALLOC) && in_range && !found_reg && c_free[0]
                        && (CW'(c_bytes[0]) >= CW'(need_reg));
    assign append_now = (state_reg == S_ALLOC) && (step_reg == count_reg) && !found_reg
                        && room;
    assign match      = (state_reg == S_FIND) && in_range && !found_reg
                        && (head_addr == CW'(faddr_reg));
    assign merge_now  = (state_reg == S_MERGE) && in_range && prev_ok_reg && c_free[0];
    assign found_any  = found_reg || fit || match;
    assign load       = (state_reg == S_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        merges_next   = merges_reg;
        found_next    = found_reg;
        prev_ok_next  = prev_ok_reg;
        heap_top_next = heap_top_reg;
        need_next     = need_reg;
        faddr_next    = faddr_reg;
        res_next      = res_reg;
        status_next   = status_reg;
        tail_start    = c_start[0];
        tail_bytes    = c_bytes[0];
        tail_free     = c_free[0];
        tail_keep     = c_keep[0];
        merge_kill    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    need_next   = need_in;
                    faddr_next  = s_tdata[31:16];
                    step_next   = '0;
                    found_next  = 1'b0;
                    res_next    = '0;
                    status_next = ffa_pkg::ST_OK;
                    if (s_tuser[0] == ffa_pkg::OP_ALLOC)
                    begin
                        state_next = S_ALLOC;
                    end
                    else if (s_tdata[31:16] == '0)
                    begin
                        status_next = ffa_pkg::ST_NULL;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIND;
                    end
                end
            end
            S_ALLOC:
            begin
                if (fit)
                begin
                    tail_free  = 1'b0;
                    found_next = 1'b1;
                    res_next   = ffa_pkg::ADDR_W'(head_addr);
                end
                else if (append_now)
                begin
                    tail_start = heap_top_reg;
                    tail_bytes = AW'(need_reg);
                    tail_free  = 1'b0;
                end
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                    if (!found_any)
                    begin
                        if (count_reg == CNTW'(MAX_BLOCKS))
                        begin
                            status_next = ffa_pkg::ST_FULL;
                        end
                        else if (!room)
                        begin
                            status_next = ffa_pkg::ST_OOM;
                        end
                        else
                        begin
                            count_next    = count_reg + 1'b1;
                            heap_top_next = AW'(end_addr);
                            res_next      = ffa_pkg::ADDR_W'(top_hdr);
                        end
                    end
                end
            end
            S_FIND:
            begin
                if (match)
                begin
                    tail_free  = 1'b1;
                    found_next = 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    step_next    = '0;
                    prev_ok_next = 1'b0;
                    merges_next  = '0;
                    if (found_any)
                    begin
                        state_next = S_MERGE;
                    end
                    else
                    begin
                        status_next = ffa_pkg::ST_UNKNOWN;
                        state_next  = S_DONE;
                    end
                end
            end
            S_MERGE:
            begin
                // the entry pushed last cycle sits in the last cell
                if (merge_now)
                begin
                    tail_start  = c_start[MAX_BLOCKS-1];
                    tail_bytes  = AW'(CW'(c_bytes[MAX_BLOCKS-1]) + CW'(c_bytes[0])
                                  + CW'(ffa_pkg::HEADER_BYTES));
                    tail_free   = 1'b1;
                    tail_keep   = 1'b1;
                    merge_kill  = 1'b1;
                    merges_next = merges_reg + 1'b1;
                end
                else
                begin
                    tail_keep = in_range;
                end
                prev_ok_next = in_range && c_free[0] && !merge_now;
                step_next    = step_reg + 1'b1;
                if (step_last)
                begin
                    step_next  = '0;
                    count_next = count_reg - merges_next;
                    state_next = S_PACK;
                end
            end
            S_PACK:
            begin
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    step_next  = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // odd-even transposition: move kept entries ahead of dropped ones, order held
    always_comb
    begin
        for (int k = 0; k < MAX_BLOCKS - 1; k++)
        begin
            swap[k] = (state_reg == S_PACK) && ((k % 2) == int'(step_reg[0]))
                      && !c_keep[k] && c_keep[k+1];
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++)
        begin : g_cell
            ffa_pkg::cell_ctl_t ctl;
            logic [AW-1:0] r_start, r_bytes, l_start, l_bytes;
            logic          r_free, r_keep, l_free, l_keep;
            logic          take_r, take_l;

            if (g == MAX_BLOCKS - 1)
            begin : g_tail
                assign r_start = tail_start;
                assign r_bytes = tail_bytes;
                assign r_free  = tail_free;
                assign r_keep  = tail_keep;
                assign take_r  = 1'b0;
            end
            else
            begin : g_body
                assign r_start = c_start[g+1];
                assign r_bytes = c_bytes[g+1];
                assign r_free  = c_free[g+1];
                assign r_keep  = c_keep[g+1];
                assign take_r  = swap[g];
            end

            if (g == 0)
            begin : g_head
                assign l_start = c_start[g];
                assign l_bytes = c_bytes[g];
                assign l_free  = c_free[g];
                assign l_keep  = c_keep[g];
                assign take_l  = 1'b0;
            end
            else
            begin : g_left
                assign l_start = c_start[g-1];
                assign l_bytes = c_bytes[g-1];
                assign l_free  = c_free[g-1];
                assign l_keep  = c_keep[g-1];
                assign take_l  = swap[g-1];
            end

            always_comb
            begin
                ctl.kill = merge_kill && (g == MAX_BLOCKS - 2);
                priority if ((state_reg == S_ALLOC) || (state_reg == S_FIND)
                             || (state_reg == S_MERGE) || take_r)
                begin
                    ctl.sel = ffa_pkg::CELL_TAKE_RIGHT;
                end
                else if (take_l)
                begin
                    ctl.sel = ffa_pkg::CELL_TAKE_LEFT;
                end
                else
                begin
                    ctl.sel = ffa_pkg::CELL_HOLD;
                end
            end

            ffa_cell #(
                .AW (AW)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .right_start (r_start),
                .right_bytes (r_bytes),
                .right_free  (r_free),
                .right_keep  (r_keep),
                .left_start  (l_start),
                .left_bytes  (l_bytes),
                .left_free   (l_free),
                .left_keep   (l_keep),
                .start       (c_start[g]),
                .bytes       (c_bytes[g]),
                .free        (c_free[g]),
                .keep        (c_keep[g])
            );
        end
    endgenerate

    // output register: hold the result until the beat is taken
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        if (m_tvalid && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = res_reg;
            out_status_next = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            merges_reg    <= '0;
            found_reg     <= 1'b0;
            prev_ok_reg   <= 1'b0;
            heap_top_reg  <= '0;
            limit_reg     <= ffa_pkg::LIMIT_W'(ffa_pkg::LIMIT_RST);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            merges_reg    <= merges_next;
            found_reg     <= found_next;
            prev_ok_reg   <= prev_ok_next;
            heap_top_reg  <= heap_top_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        faddr_reg      <= faddr_next;
        res_reg        <= res_next;
        status_reg     <= status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_status_reg, out_addr_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_BLOCKS))
        else $error("block count above table depth");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ffa_pkg::ST_OK)) |-> (out_addr_reg == '0))
        else $error("failed request carries an address");

    a_top_grows: assert property (@(posedge clk) disable iff (!rst_n)
        heap_top_reg >= $past(heap_top_reg))
        else $error("heap top moved down");

    a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> (merges_reg <= count_reg))
        else $error("more merges than blocks");

    a_top_limit: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(heap_top_reg) <= CW'(HEAP_BYTES))
        else $error("heap top beyond arena");
`endif

endmodule
